### rtl/mfcs_pkg.sv
// Shared types and constants of the meter frame checksum and scaling block.
// Used by meter_frame_checksum_and_scaling_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mfcs_pkg;

    // Width of the frame byte counter
    localparam int POS_W = 5;

    // First frame byte of each little-endian 24-bit field
    localparam int POS_CUR   = 1;
    localparam int POS_VOLT  = 4;
    localparam int POS_POW   = 10;
    localparam int POS_PULSE = 13;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CMD   = 3'd0,
        CFG_CUR   = 3'd1,
        CFG_VOLT  = 3'd2,
        CFG_POW   = 3'd3,
        CFG_PULSE = 3'd4
    } t_cfg_idx;

    // Lanes of the shift-add multiplier and the bit-serial divider
    localparam int LANES = 4;
    localparam int LANE_CUR   = 0;
    localparam int LANE_VOLT  = 1;
    localparam int LANE_POW   = 2;
    localparam int LANE_PULSE = 3;

    // Scale constants, consumed MSB first
    localparam int MUL_STEPS = 14;
    localparam int CNT_W     = 6;
    localparam logic [MUL_STEPS-1:0] MUL_K [LANES] = '{
        14'd1000, 14'd100, 14'd1000, 14'd10000
    };

    // Product and quotient width of each lane
    localparam int Q_W [LANES] = '{34, 31, 33, 62};
    localparam int DIV_STEPS = 62;
    localparam int MC_W      = 48;
    localparam int DIV_W     = 24;

    // Control state, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_DIV  = 3'b100
    } t_state;

endpackage

`default_nettype wire

### rtl/meter_frame_checksum_and_scaling_top.sv
// Top level of the meter frame checksum and scaling block: byte capture,
// checksum check, pulse total and bit-serial scaling. Uses mfcs_pkg.
//
// Usage:
//   s_axis carries one response byte per item (tdata) and a frame start
//   flag (tuser). Each frame is FRAME_BYTES bytes followed by a checksum
//   byte; frame start forces the byte to be frame byte 0.
//   m_axis carries one result item per checksum byte: frame_ok in tuser,
//   scaled current, voltage, power, the pulse count and energy in tdata.
//   The cfg channel writes the command byte and the four divisors; it is
//   always ready and is meant to be written while the block is idle.
// Timing:
//   Frame bytes are taken back to back while idle. A bad checksum gives
//   its result in the cycle after the byte. A good frame runs a shift-add
//   multiply over the bits of the longest scale constant (14 bits), then a
//   restoring divide over the bits of the widest quotient, energy (62
//   bits); the result is registered as the divide ends, and no byte is taken meanwhile.
// Reset and stall:
//   Reset clears the byte position, checksum sum, captured fields and the
//   pulse total, and loads the command byte 88 and divisors of 1. While
//   a result waits, frame bytes are still taken; a checksum byte waits
//   until the pending result is taken.
`timescale 1ns / 1ps
`default_nettype none

module meter_frame_checksum_and_scaling_top #(
    parameter int FRAME_BYTES = 22
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // cfg write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [23:0]  i_cfg_data,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]   s_axis_tuser,   // [0] frame_start
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [183:0]      m_axis_tdata,   // [33:0] current_scaled,
                                              // [64:34] voltage_scaled,
                                              // [97:65] power_scaled,
                                              // [121:98] pulse_count,
                                              // [183:122] energy_scaled
    output logic [0:0]        m_axis_tuser    // [0] frame_ok
);

    localparam int PW = mfcs_pkg::POS_W;

    // Configuration registers
    logic [7:0]  r_cmd;
    logic [23:0] r_div [mfcs_pkg::LANES];

    // Frame capture state
    logic [PW-1:0] r_pos;
    logic [7:0]    r_sum;
    logic [23:0]   r_cur_raw, r_volt_raw, r_pow_raw, r_pulse_raw;
    logic [47:0]   r_total;

    // Control and output state
    mfcs_pkg::t_state            r_state;
    logic [mfcs_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_out_valid;
    logic                        r_out_ok;
    logic [23:0]                 r_out_pulse;

    logic [PW-1:0] w_pos;
    logic          w_is_cks;
    logic          w_in_acc;
    logic          w_cks_ok;
    logic          w_start;
    logic          w_div_end;
    logic [7:0]    w_base;
    logic [24:0]   w_pow_mag;
    logic [48:0]   w_total_sum;
    logic [mfcs_pkg::MC_W-1:0]  w_mcand [mfcs_pkg::LANES];
    logic [mfcs_pkg::DIV_W-1:0] w_div_eff [mfcs_pkg::LANES];
    logic [mfcs_pkg::DIV_STEPS-1:0] w_quot [mfcs_pkg::LANES];
    logic [3:0] w_kbit_idx;

    // Configuration writes, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= 8'd88;
            for (int k = 0; k < mfcs_pkg::LANES; k++) begin
                r_div[k] <= 24'd1;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mfcs_pkg::CFG_CMD)   r_cmd <= i_cfg_data[7:0];
            if (i_cfg_index == mfcs_pkg::CFG_CUR)   r_div[mfcs_pkg::LANE_CUR] <= i_cfg_data;
            if (i_cfg_index == mfcs_pkg::CFG_VOLT)  r_div[mfcs_pkg::LANE_VOLT] <= i_cfg_data;
            if (i_cfg_index == mfcs_pkg::CFG_POW)   r_div[mfcs_pkg::LANE_POW] <= i_cfg_data;
            if (i_cfg_index == mfcs_pkg::CFG_PULSE) r_div[mfcs_pkg::LANE_PULSE] <= i_cfg_data;
        end
    end

    // Decode the incoming byte's place in the frame
    assign w_pos    = s_axis_tuser[0] ? '0 : r_pos;
    assign w_is_cks = (w_pos == PW'(FRAME_BYTES));
    assign w_base   = (w_pos == '0) ? r_cmd : r_sum;
    assign w_cks_ok = (s_axis_tdata == ~r_sum);
    assign s_axis_tready = (r_state == mfcs_pkg::ST_IDLE)
                         && (!w_is_cks || !r_out_valid || m_axis_tready);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_start  = w_in_acc && w_is_cks && w_cks_ok;

    // Power magnitude and saturating pulse sum
    assign w_pow_mag   = r_pow_raw[23] ? (25'h1000000 - {1'b0, r_pow_raw})
                                       : {1'b0, r_pow_raw};
    assign w_total_sum = {1'b0, r_total} + {25'd0, r_pulse_raw};

    // Capture frame bytes, check the checksum, update the total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_cur_raw   <= '0;
            r_volt_raw  <= '0;
            r_pow_raw   <= '0;
            r_pulse_raw <= '0;
            r_total     <= '0;
        end else if (w_in_acc) begin
            if (!w_is_cks) begin
                r_sum <= w_base + s_axis_tdata;
                r_pos <= w_pos + PW'(1);
                if (w_pos >= PW'(mfcs_pkg::POS_CUR) && w_pos < PW'(mfcs_pkg::POS_CUR + 3))
                    r_cur_raw[8*(w_pos - PW'(mfcs_pkg::POS_CUR)) +: 8] <= s_axis_tdata;
                if (w_pos >= PW'(mfcs_pkg::POS_VOLT) && w_pos < PW'(mfcs_pkg::POS_VOLT + 3))
                    r_volt_raw[8*(w_pos - PW'(mfcs_pkg::POS_VOLT)) +: 8] <= s_axis_tdata;
                if (w_pos >= PW'(mfcs_pkg::POS_POW) && w_pos < PW'(mfcs_pkg::POS_POW + 3))
                    r_pow_raw[8*(w_pos - PW'(mfcs_pkg::POS_POW)) +: 8] <= s_axis_tdata;
                if (w_pos >= PW'(mfcs_pkg::POS_PULSE) && w_pos < PW'(mfcs_pkg::POS_PULSE + 3))
                    r_pulse_raw[8*(w_pos - PW'(mfcs_pkg::POS_PULSE)) +: 8] <= s_axis_tdata;
            end else begin
                r_pos <= '0;
                if (w_cks_ok) begin
                    r_total <= w_total_sum[48] ? '1 : w_total_sum[47:0];
                end
            end
        end
    end

    // Sequence the multiply and divide phases
    assign w_div_end = (r_state == mfcs_pkg::ST_DIV)
                     && (r_cnt == mfcs_pkg::CNT_W'(mfcs_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfcs_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                mfcs_pkg::ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_start) r_state <= mfcs_pkg::ST_MUL;
                end
                mfcs_pkg::ST_MUL: begin
                    if (r_cnt == mfcs_pkg::CNT_W'(mfcs_pkg::MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= mfcs_pkg::ST_DIV;
                    end else begin
                        r_cnt <= r_cnt + mfcs_pkg::CNT_W'(1);
                    end
                end
                mfcs_pkg::ST_DIV: begin
                    if (w_div_end) begin
                        r_cnt   <= '0;
                        r_state <= mfcs_pkg::ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + mfcs_pkg::CNT_W'(1);
                    end
                end
                default: r_state <= mfcs_pkg::ST_IDLE;
            endcase
        end
    end

    // Lane operands; a zero divisor acts as one
    assign w_mcand[mfcs_pkg::LANE_CUR]   = {24'd0, r_cur_raw};
    assign w_mcand[mfcs_pkg::LANE_VOLT]  = {24'd0, r_volt_raw};
    assign w_mcand[mfcs_pkg::LANE_POW]   = {23'd0, w_pow_mag};
    assign w_mcand[mfcs_pkg::LANE_PULSE] = r_total;
    assign w_kbit_idx = 4'(mfcs_pkg::MUL_STEPS - 1) - r_cnt[3:0];

    for (genvar k = 0; k < mfcs_pkg::LANES; k++) begin : g_lane
        localparam int W = mfcs_pkg::Q_W[k];
        logic [W-1:0]               r_dq;
        logic [mfcs_pkg::DIV_W-1:0] r_rem;
        logic [mfcs_pkg::DIV_W:0]   w_trial;
        logic                       w_ge;
        logic                       w_step;

        assign w_div_eff[k] = (r_div[k] == '0) ? 24'd1 : r_div[k];
        assign w_trial = {r_rem, r_dq[W-1]};
        assign w_ge    = (w_trial >= {1'b0, w_div_eff[k]});
        // narrower lanes start late so that all quotients finish together
        assign w_step  = (r_state == mfcs_pkg::ST_DIV)
                       && (r_cnt >= mfcs_pkg::CNT_W'(mfcs_pkg::DIV_STEPS - W));

        // Accumulate the product, then shift it out into the quotient
        always_ff @(posedge i_clk) begin
            if (w_start) begin
                r_dq  <= '0;
                r_rem <= '0;
            end else if (r_state == mfcs_pkg::ST_MUL) begin
                r_dq <= {r_dq[W-2:0], 1'b0}
                      + (mfcs_pkg::MUL_K[k][w_kbit_idx] ? W'(w_mcand[k]) : W'(0));
            end else if (w_step) begin
                r_rem <= w_ge ? mfcs_pkg::DIV_W'(w_trial - {1'b0, w_div_eff[k]})
                              : w_trial[mfcs_pkg::DIV_W-1:0];
                r_dq  <= {r_dq[W-2:0], w_ge};
            end
        end

        assign w_quot[k] = mfcs_pkg::DIV_STEPS'(r_dq);
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_in_acc && w_is_cks && !w_cks_ok) || w_div_end) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_cks) begin
            r_out_ok    <= w_cks_ok;
            r_out_pulse <= w_cks_ok ? r_pulse_raw : 24'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = r_out_ok
        ? {w_quot[mfcs_pkg::LANE_PULSE],
           r_out_pulse,
           w_quot[mfcs_pkg::LANE_POW][32:0],
           w_quot[mfcs_pkg::LANE_VOLT][30:0],
           w_quot[mfcs_pkg::LANE_CUR][33:0]}
        : {160'd0, r_out_pulse};

    // Checks
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mfcs_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while scaling is in progress");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(FRAME_BYTES))
        else $error("byte position ran past the checksum byte");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(w_div_end)
                                || $past(w_in_acc && w_is_cks && !w_cks_ok)))
        else $error("result appeared without a checksum byte or divide end");

    a_total_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_total) |-> $past(w_start))
        else $error("pulse total changed without a good frame");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_end |-> !r_out_valid)
        else $error("finished result would overwrite a pending one");

endmodule

`default_nettype wire
